@@ sv/agm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agm_pkg: shared types and constants
// Sizes, command codes, controller states and the controller/datapath structs.
// ----------------------------------------------------------------------------
package agm_pkg;

    localparam int MAX_VERTICES   = 16;
    localparam int IDX_W          = $clog2(MAX_VERTICES);
    localparam int CNT_W          = IDX_W + 1;
    localparam int ADDR_W         = 2 * IDX_W;
    localparam int WEIGHT_BITS    = 16;
    localparam int LABEL_W        = 8;
    localparam int ARC_W          = 8;
    localparam int NO_EDGE_WEIGHT = 32767;

    typedef enum logic [2:0] {
        CMD_INS_VERTEX = 3'd0,
        CMD_DEL_VERTEX = 3'd1,
        CMD_INS_ARC    = 3'd2,
        CMD_DEL_ARC    = 3'd3,
        CMD_LOCATE     = 3'd4,
        CMD_READ_ARC   = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL,
        ST_COUNT,
        ST_MOVE,
        ST_DEL_FIN,
        ST_ARC,
        ST_MIRROR,
        ST_DONE
    } state_t;

    typedef enum logic {
        WR_NO_EDGE,
        WR_WEIGHT
    } wr_sel_t;

    typedef enum logic {
        LBL_FROM_INPUT,
        LBL_FROM_TABLE
    } lbl_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic                   capture;
        logic                   scan_en;
        logic [IDX_W-1:0]       lbl_idx;
        logic                   lbl_wr;
        logic [IDX_W-1:0]       lbl_wr_idx;
        lbl_sel_t               lbl_sel;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
        logic                   chk;
        logic                   mv;
        logic [ADDR_W-1:0]      mv_dst;
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        wr_sel_t                wr_sel;
        logic                   arc_eval;
        logic                   vc_inc;
        logic                   vc_dec;
        logic                   finish;
        logic                   err;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0]             cmd;
        logic [CNT_W-1:0]       n;
        logic                   fa;
        logic                   fb;
        logic [IDX_W-1:0]       ka;
        logic [IDX_W-1:0]       kb;
        logic                   undirected;
        logic                   w_is_no_edge;
        logic                   out_free;
    } dp_stat_t;

endpackage

@@ sv/agm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agm_datapath: label table, adjacency memory, counts and result register
// Executes the micro-commands issued by the controller.
// ----------------------------------------------------------------------------
module agm_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  agm_pkg::dp_cmd_t          cmd,
    output agm_pkg::dp_stat_t         stat,
    input  logic [34:0]               in_word,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_kind,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [34:0]               out_word
);

    logic [agm_pkg::LABEL_W-1:0]          label_reg [agm_pkg::MAX_VERTICES];
    logic signed [agm_pkg::WEIGHT_BITS-1:0] adj_mem [agm_pkg::MAX_VERTICES*agm_pkg::MAX_VERTICES];
    logic signed [agm_pkg::WEIGHT_BITS-1:0] rdata_reg;

    logic [1:0]                       kind_reg;
    logic [agm_pkg::CNT_W-1:0]        vcount_reg;
    logic [agm_pkg::ARC_W-1:0]        acount_reg, acount_next;
    logic [2:0]                       op_reg;
    logic [agm_pkg::LABEL_W-1:0]      a_reg, b_reg;
    logic signed [15:0]               w_reg;
    logic                             fa_reg, fb_reg;
    logic [agm_pkg::IDX_W-1:0]        ka_reg, kb_reg;
    logic                             chk_d_reg, mv_d_reg;
    logic [agm_pkg::ADDR_W-1:0]       mv_dst_d_reg;
    logic signed [15:0]               val_reg;
    logic                             conn_reg;
    logic                             out_valid_reg;
    logic [34:0]                      out_reg;

    logic signed [agm_pkg::WEIGHT_BITS-1:0] no_edge, arc_val, wr_data;
    logic [agm_pkg::LABEL_W-1:0]      lbl_rd;
    logic                             wr_go;
    logic [agm_pkg::ADDR_W-1:0]       wr_addr;
    logic                             cell_set;
    logic [agm_pkg::IDX_W-1:0]        found;

    assign no_edge  = kind_reg[0] ? agm_pkg::WEIGHT_BITS'(agm_pkg::NO_EDGE_WEIGHT)
                                  : '0;
    assign arc_val  = kind_reg[0] ? w_reg : agm_pkg::WEIGHT_BITS'(1);
    assign lbl_rd   = label_reg[cmd.lbl_idx];
    assign cell_set = (rdata_reg != no_edge);

    assign wr_go   = cmd.wr_en | mv_d_reg;
    assign wr_addr = mv_d_reg ? mv_dst_d_reg : cmd.wr_addr;
    always_comb
    begin
        if (mv_d_reg)
            wr_data = rdata_reg;
        else if (cmd.wr_sel == agm_pkg::WR_WEIGHT)
            wr_data = arc_val;
        else
            wr_data = no_edge;
    end

    // adjacency memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_go)
            adj_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= adj_mem[cmd.rd_addr];
    end

    // label table
    always_ff @(posedge clk)
    begin
        if (cmd.lbl_wr)
            label_reg[cmd.lbl_wr_idx] <= (cmd.lbl_sel == agm_pkg::LBL_FROM_TABLE) ? lbl_rd
                                                                                 : a_reg;
    end

    // saturating arc count update
    always_comb
    begin
        acount_next = acount_reg;
        if (chk_d_reg && cell_set && acount_reg != '0)
            acount_next = acount_reg - 1'b1;
        if (cmd.arc_eval)
        begin
            if (op_reg == agm_pkg::CMD_INS_ARC && !cell_set && acount_reg != '1)
                acount_next = acount_reg + 1'b1;
            else if (op_reg == agm_pkg::CMD_DEL_ARC && cell_set && acount_reg != '0)
                acount_next = acount_reg - 1'b1;
        end
    end

    assign found = (!cmd.err && op_reg == agm_pkg::CMD_LOCATE) ? ka_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= '0;
            vcount_reg    <= '0;
            acount_reg    <= '0;
            chk_d_reg     <= 1'b0;
            mv_d_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                kind_reg <= cfg_kind;
            acount_reg <= acount_next;
            if (cmd.vc_inc)
                vcount_reg <= vcount_reg + 1'b1;
            else if (cmd.vc_dec)
                vcount_reg <= vcount_reg - 1'b1;
            chk_d_reg <= cmd.chk;
            mv_d_reg  <= cmd.mv;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_dst_d_reg <= cmd.mv_dst;
        if (cmd.capture)
        begin
            op_reg   <= in_word[2:0];
            a_reg    <= in_word[10:3];
            b_reg    <= in_word[18:11];
            w_reg    <= in_word[34:19];
            fa_reg   <= 1'b0;
            fb_reg   <= 1'b0;
            ka_reg   <= '0;
            kb_reg   <= '0;
            val_reg  <= '0;
            conn_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_en && lbl_rd == a_reg && !fa_reg)
            begin
                fa_reg <= 1'b1;
                ka_reg <= cmd.lbl_idx;
            end
            if (cmd.scan_en && lbl_rd == b_reg && !fb_reg)
            begin
                fb_reg <= 1'b1;
                kb_reg <= cmd.lbl_idx;
            end
            if (cmd.arc_eval && op_reg == agm_pkg::CMD_READ_ARC)
            begin
                val_reg  <= rdata_reg;
                conn_reg <= cell_set;
            end
        end
        if (cmd.finish)
            out_reg <= {acount_reg, vcount_reg, conn_reg, val_reg, found, cmd.err};
    end

    assign stat.cmd          = op_reg;
    assign stat.n            = vcount_reg;
    assign stat.fa           = fa_reg;
    assign stat.fb           = fb_reg;
    assign stat.ka           = ka_reg;
    assign stat.kb           = kb_reg;
    assign stat.undirected   = kind_reg[1];
    assign stat.w_is_no_edge = kind_reg[0] && (w_reg == no_edge);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    a_vcount_max: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= agm_pkg::CNT_W'(agm_pkg::MAX_VERTICES))
        else $error("vertex count above table size");
    a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && mv_d_reg))
        else $error("write port conflict during compaction");
    a_chk_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk |=> $past(cmd.rd_en))
        else $error("arc check without a matrix read");

endmodule

@@ sv/agm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agm_ctrl: command sequencer
// Label scan, then the per-command sweep over matrix cells.
// ----------------------------------------------------------------------------
module agm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  agm_pkg::dp_stat_t     stat,
    output agm_pkg::dp_cmd_t      cmd
);

    agm_pkg::state_t              state_reg, state_next;
    logic [agm_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [agm_pkg::IDX_W-1:0]    j_reg, j_next;
    logic                         p_reg, p_next;
    logic                         err_reg, err_next;

    logic [agm_pkg::IDX_W-1:0]    ii, nn, ri, rj;
    logic                         last_i, last_j;

    assign ii     = i_reg[agm_pkg::IDX_W-1:0];
    assign nn     = stat.n[agm_pkg::IDX_W-1:0];
    assign last_i = (i_reg == stat.n - 1'b1);
    assign last_j = ({1'b0, j_reg} == stat.n - 1'b1);
    // destination of a kept cell after removing row/column ka
    assign ri     = ii - agm_pkg::IDX_W'(ii > stat.ka);
    assign rj     = j_reg - agm_pkg::IDX_W'(j_reg > stat.ka);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= agm_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        err_next   = err_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.err    = err_reg;
        cmd.lbl_idx = ii;

        case (state_reg)
            agm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    i_next      = '0;
                    err_next    = 1'b0;
                    state_next  = agm_pkg::ST_SCAN;
                end
            end
            agm_pkg::ST_SCAN:
            begin
                if (i_reg == stat.n)
                    state_next = agm_pkg::ST_DECIDE;
                else
                begin
                    cmd.scan_en = 1'b1;
                    i_next      = i_reg + 1'b1;
                end
            end
            agm_pkg::ST_DECIDE:
            begin
                i_next     = '0;
                j_next     = '0;
                p_next     = 1'b0;
                state_next = agm_pkg::ST_DONE;
                cmd.rd_addr = {stat.ka, stat.kb};
                case (stat.cmd)
                    agm_pkg::CMD_INS_VERTEX:
                    begin
                        if (stat.n < agm_pkg::CNT_W'(agm_pkg::MAX_VERTICES) && !stat.fa)
                        begin
                            cmd.lbl_wr     = 1'b1;
                            cmd.lbl_wr_idx = nn;
                            cmd.lbl_sel    = agm_pkg::LBL_FROM_INPUT;
                            state_next     = agm_pkg::ST_FILL;
                        end
                        else
                            err_next = 1'b1;
                    end
                    agm_pkg::CMD_DEL_VERTEX:
                    begin
                        if (stat.fa)
                            state_next = agm_pkg::ST_COUNT;
                        else
                            err_next = 1'b1;
                    end
                    agm_pkg::CMD_INS_ARC:
                    begin
                        if (stat.fa && stat.fb && stat.ka != stat.kb && !stat.w_is_no_edge)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = agm_pkg::ST_ARC;
                        end
                        else
                            err_next = 1'b1;
                    end
                    agm_pkg::CMD_DEL_ARC, agm_pkg::CMD_READ_ARC:
                    begin
                        if (stat.fa && stat.fb)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = agm_pkg::ST_ARC;
                        end
                        else
                            err_next = 1'b1;
                    end
                    agm_pkg::CMD_LOCATE:
                    begin
                        if (!stat.fa)
                            err_next = 1'b1;
                    end
                    default:
                        err_next = 1'b1;
                endcase
            end
            agm_pkg::ST_FILL:
            begin
                // new row and column get the no-edge value, i = 0..n
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = agm_pkg::WR_NO_EDGE;
                cmd.wr_addr = p_reg ? {nn, ii} : {ii, nn};
                if (p_reg)
                begin
                    p_next = 1'b0;
                    if (i_reg == stat.n)
                    begin
                        cmd.vc_inc = 1'b1;
                        state_next = agm_pkg::ST_DONE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    p_next = 1'b1;
            end
            agm_pkg::ST_COUNT:
            begin
                // row ka, and column ka for directed kinds
                cmd.rd_en   = 1'b1;
                cmd.chk     = 1'b1;
                cmd.rd_addr = p_reg ? {ii, stat.ka} : {stat.ka, ii};
                if (!stat.undirected && !p_reg)
                    p_next = 1'b1;
                else
                begin
                    p_next = 1'b0;
                    if (last_i)
                    begin
                        i_next     = '0;
                        state_next = agm_pkg::ST_MOVE;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
            end
            agm_pkg::ST_MOVE:
            begin
                // row-major copy; destination never passes the read pointer
                cmd.rd_en      = 1'b1;
                cmd.rd_addr    = {ii, j_reg};
                cmd.mv         = (ii != stat.ka) && (j_reg != stat.ka);
                cmd.mv_dst     = {ri, rj};
                cmd.lbl_wr     = (j_reg == '0) && (ii != stat.ka);
                cmd.lbl_wr_idx = ri;
                cmd.lbl_sel    = agm_pkg::LBL_FROM_TABLE;
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                        state_next = agm_pkg::ST_DEL_FIN;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            agm_pkg::ST_DEL_FIN:
            begin
                cmd.vc_dec = 1'b1;
                state_next = agm_pkg::ST_DONE;
            end
            agm_pkg::ST_ARC:
            begin
                cmd.arc_eval = 1'b1;
                cmd.wr_addr  = {stat.ka, stat.kb};
                cmd.wr_sel   = (stat.cmd == agm_pkg::CMD_INS_ARC) ? agm_pkg::WR_WEIGHT
                                                                  : agm_pkg::WR_NO_EDGE;
                if (stat.cmd == agm_pkg::CMD_READ_ARC)
                    state_next = agm_pkg::ST_DONE;
                else
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = stat.undirected ? agm_pkg::ST_MIRROR : agm_pkg::ST_DONE;
                end
            end
            agm_pkg::ST_MIRROR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = {stat.kb, stat.ka};
                cmd.wr_sel  = (stat.cmd == agm_pkg::CMD_INS_ARC) ? agm_pkg::WR_WEIGHT
                                                                 : agm_pkg::WR_NO_EDGE;
                state_next  = agm_pkg::ST_DONE;
            end
            agm_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = agm_pkg::ST_IDLE;
                end
            end
            default:
                state_next = agm_pkg::ST_IDLE;
        endcase
    end

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == agm_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("two results for one word");
    a_move_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == agm_pkg::ST_MOVE) |-> (i_reg < stat.n))
        else $error("compaction past last row");

endmodule

@@ sv/adjacency_matrix_graph_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store: graph store with label table and matrix
// Top level: stream ports, configuration write channel, controller+datapath.
// ----------------------------------------------------------------------------
// Sequence per word: label scan, decide, command body, result load.
// One word at a time: the next word is taken only after the result for the last
//   one loads, and output stalls hold back that result load.
// Reset: counts and graph kind clear, label table and matrix are not cleared.
module adjacency_matrix_graph_store
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], vertex_a[10:3], vertex_b[18:11], weight[34:19], zero pad
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0], found_index[4:1], arc_value[20:5], connected[21],
    // vertex_total[26:22], arc_total[34:27], zero pad
    output logic [39:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);

    agm_pkg::dp_cmd_t    cmd;
    agm_pkg::dp_stat_t   stat;
    logic [34:0]         out_word;

    // the user writes the graph kind only while idle; the block does not enforce it and always takes it
    assign cfg_ready = 1'b1;

    agm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    agm_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_axis_tdata[34:0]),
        .cfg_we    (cfg_valid),
        .cfg_kind  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {5'b0, out_word};

endmodule

@@ sim/graph_store_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_store_checker: result predictor and scoreboard
// Mirrors the label table and matrix, predicts one result word per command
// word and compares each output word against the oldest prediction.
// ----------------------------------------------------------------------------
module graph_store_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);

    // lowest field last
    typedef struct packed {
        logic [7:0]  arc_total;
        logic [4:0]  vertex_total;
        logic        connected;
        logic [15:0] arc_value;
        logic [3:0]  found_index;
        logic        status;
    } graph_result_t;

    logic [7:0]        labels [agm_pkg::MAX_VERTICES];
    logic signed [15:0] matrix [agm_pkg::MAX_VERTICES][agm_pkg::MAX_VERTICES];
    int                n_vert;
    int                n_arcs;
    logic [1:0]        kind;
    graph_result_t     result_q [$];

    function automatic int find_label(logic [7:0] lbl);
        for (int i = 0; i < n_vert; i++)
            if (labels[i] == lbl)
                return i;
        return -1;
    endfunction

    function automatic void arcs_dec();
        if (n_arcs > 0) n_arcs--;
    endfunction

    function automatic graph_result_t apply_command(logic [39:0] w);
        graph_result_t      r;
        logic [2:0]         op;
        logic signed [15:0] ne;
        logic signed [15:0] wt;
        logic               weighted;
        logic               undir;
        int                 ka;
        int                 kb;
        int                 ni;
        int                 nj;
        bit                 had;
        op       = w[2:0];
        wt       = w[34:19];
        weighted = kind[0];
        undir    = kind[1];
        ne       = weighted ? 16'sd32767 : 16'sd0;
        ka       = find_label(w[10:3]);
        kb       = find_label(w[18:11]);
        r        = '0;
        r.status = 1'b1;
        case (op)
            agm_pkg::CMD_INS_VERTEX:
                if (n_vert < agm_pkg::MAX_VERTICES && ka < 0)
                begin
                    labels[n_vert] = w[10:3];
                    for (int i = 0; i <= n_vert; i++)
                    begin
                        matrix[i][n_vert] = ne;
                        matrix[n_vert][i] = ne;
                    end
                    n_vert++;
                    r.status = 1'b0;
                end
            agm_pkg::CMD_DEL_VERTEX:
                if (ka >= 0)
                begin
                    for (int i = 0; i < n_vert; i++)
                    begin
                        if (matrix[ka][i] != ne) arcs_dec();
                        if (!undir && matrix[i][ka] != ne) arcs_dec();
                    end
                    ni = 0;
                    for (int i = 0; i < n_vert; i++)
                    begin
                        if (i == ka) continue;
                        nj = 0;
                        for (int j = 0; j < n_vert; j++)
                        begin
                            if (j == ka) continue;
                            matrix[ni][nj] = matrix[i][j];
                            nj++;
                        end
                        labels[ni] = labels[i];
                        ni++;
                    end
                    n_vert--;
                    r.status = 1'b0;
                end
            agm_pkg::CMD_INS_ARC:
                if (ka >= 0 && kb >= 0 && ka != kb)
                begin
                    if (!weighted) wt = 16'sd1;
                    if (!(weighted && wt == ne))
                    begin
                        had = matrix[ka][kb] != ne;
                        matrix[ka][kb] = wt;
                        if (undir) matrix[kb][ka] = wt;
                        if (!had && n_arcs < 255) n_arcs++;
                        r.status = 1'b0;
                    end
                end
            agm_pkg::CMD_DEL_ARC:
                if (ka >= 0 && kb >= 0)
                begin
                    had = matrix[ka][kb] != ne;
                    matrix[ka][kb] = ne;
                    if (undir) matrix[kb][ka] = ne;
                    if (had) arcs_dec();
                    r.status = 1'b0;
                end
            agm_pkg::CMD_LOCATE:
                if (ka >= 0)
                begin
                    r.found_index = ka[3:0];
                    r.status      = 1'b0;
                end
            agm_pkg::CMD_READ_ARC:
                if (ka >= 0 && kb >= 0)
                begin
                    r.arc_value = matrix[ka][kb];
                    r.connected = matrix[ka][kb] != ne;
                    r.status    = 1'b0;
                end
            default: ;
        endcase
        r.vertex_total = n_vert[4:0];
        r.arc_total    = n_arcs[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        graph_result_t want;
        graph_result_t got;
        if (!rst_n)
        begin
            n_vert     <= 0;
            n_arcs     <= 0;
            kind       <= 2'd0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(apply_command(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[34:0];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want !== got || m_axis_tdata[39:35] !== 5'd0)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want,
                                 m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count = result_q.size();
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: graph store regression
// Directed and random command words over all graph kinds, random gaps on
// both streams, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb;

    // command codes with no operation behind them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    bit          gaps_on;
    bit          hold_out;
    logic [7:0]  label_pool [8];

    adjacency_matrix_graph_store i_dut (.*);

    graph_store_checker i_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // output side: random stalls, or a long hold when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_out = 1'b0;
            end
            m_axis_tready <= !(gaps_on && $urandom_range(99) < 16);
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // valid drops between words
    task automatic send_word(logic [2:0] op, logic [7:0] va, logic [7:0] vb,
                             logic [15:0] wt);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 16)
            @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, wt, vb, va, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic set_kind(logic [1:0] k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random word, mostly on labels from a small pool so lookups hit
    task automatic random_word();
        logic [2:0]  op;
        logic [7:0]  va;
        logic [7:0]  vb;
        logic [15:0] wt;
        int          p;
        p  = $urandom_range(99);
        op = (p < 25) ? agm_pkg::CMD_INS_VERTEX :
             (p < 32) ? agm_pkg::CMD_DEL_VERTEX :
             (p < 60) ? agm_pkg::CMD_INS_ARC :
             (p < 72) ? agm_pkg::CMD_DEL_ARC :
             (p < 80) ? agm_pkg::CMD_LOCATE :
             (p < 97) ? agm_pkg::CMD_READ_ARC : 3'($urandom_range(7));
        va = ($urandom_range(9) == 0) ? 8'($urandom) : label_pool[$urandom_range(7)];
        vb = ($urandom_range(9) == 0) ? 8'($urandom) : label_pool[$urandom_range(7)];
        wt = ($urandom_range(19) == 0) ? 16'h7fff : 16'($urandom);
        send_word(op, va, vb, wt);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 2'd0;
        gaps_on       = 1'b0;
        hold_out      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fill the table to the limit, duplicate, full, self loop
        for (int i = 0; i < 17; i++)
            send_word(agm_pkg::CMD_INS_VERTEX, (i == 16) ? 8'hff : 8'(i * 17), 8'h00,
                      16'h0);
        send_word(agm_pkg::CMD_INS_VERTEX, 8'h00, 8'h00, 16'h0);
        send_word(agm_pkg::CMD_INS_ARC, 8'h00, 8'hff, 16'h0);
        send_word(agm_pkg::CMD_INS_ARC, 8'h11, 8'h11, 16'h0);
        send_word(agm_pkg::CMD_DEL_ARC, 8'h11, 8'h11, 16'h0);
        send_word(agm_pkg::CMD_READ_ARC, 8'h00, 8'hff, 16'h0);
        send_word(agm_pkg::CMD_LOCATE, 8'hff, 8'h00, 16'h0);
        send_word(agm_pkg::CMD_LOCATE, 8'h01, 8'h00, 16'h0);
        send_word(agm_pkg::CMD_DEL_VERTEX, 8'h00, 8'h00, 16'h0);
        send_word(CMD_SPARE_LO, 8'h00, 8'h00, 16'h0);
        send_word(CMD_SPARE_HI, 8'hff, 8'hff, 16'hffff);

        // weighted kind: extremes, no-edge weight, kind change with graph present
        set_kind(2'd3);
        send_word(agm_pkg::CMD_INS_ARC, 8'h11, 8'h22, 16'h8000);
        send_word(agm_pkg::CMD_INS_ARC, 8'h22, 8'h33, 16'h7ffe);
        send_word(agm_pkg::CMD_INS_ARC, 8'h33, 8'h44, 16'h7fff);
        send_word(agm_pkg::CMD_READ_ARC, 8'h22, 8'h11, 16'h0);
        send_word(agm_pkg::CMD_DEL_VERTEX, 8'hff, 8'h00, 16'h0);
        set_kind(2'd0);
        send_word(agm_pkg::CMD_DEL_VERTEX, 8'h22, 8'h00, 16'h0);

        // random phases over every kind; emptying the table now and then
        label_pool = '{8'h00, 8'h5a, 8'ha5, 8'hff, 8'h01, 8'h80, 8'h7f, 8'h3c};
        gaps_on = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_kind(2'(ph));
            if (ph == 4)
                gaps_on = 1'b0;
            if (ph == 5)
                gaps_on = 1'b1;
            if (ph == 2)
                hold_out = 1'b1;
            for (int i = 0; i < 135; i++)
                random_word();
            for (int i = 0; i < 8; i++)
                send_word(agm_pkg::CMD_DEL_VERTEX, label_pool[i], 8'h00, 16'h0);
        end

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
